// ----- rtl/srs_pkg.sv -----
package srs_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_BITS_DEF    = 64;
    localparam int TAG_BITS_DEF    = 16;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the new record, shift larger ones up
        logic advance;  // move every record one cell toward the output
    } t_cell_ctl;

endpackage

// ----- rtl/stable_record_sorter.sv -----
// Stable record sorter.
// Input channel (i_in_valid / o_in_stall): one record per transaction, key,
// tag and a last_record mark. While loading, a record is taken every cycle and
// goes straight to its sorted place in a chain of MAX_RECORDS cells.
// Output channel (o_out_valid / i_out_stall): on the transaction marked last,
// the batch is emitted from the head of the chain in ascending key order, one
// record per cycle unless i_out_stall holds it, starting the cycle after the
// last record was taken. Equal keys come out in arrival order. o_end_of_batch
// marks the final record. While the batch drains, o_in_stall is high.
// Records beyond capacity are dropped and every result of that batch carries
// o_overflow. A stall on the output holds the chain and the shown result.
// Synchronous reset empties the chain; stored keys need no clearing pass.
module stable_record_sorter
    import srs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic                i_last_record,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KEY_BITS-1:0] o_sorted_key,
    output logic [TAG_BITS-1:0] o_sorted_tag,
    output logic                o_end_of_batch,
    output logic                o_overflow
);

    logic                r_drain;
    logic                n_drain;
    logic                r_ovf;
    logic                n_ovf;
    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_full;
    t_cell_ctl           w_ctl;

    logic                w_valid   [MAX_RECORDS];
    logic [KEY_BITS-1:0] w_key     [MAX_RECORDS];
    logic [TAG_BITS-1:0] w_tag     [MAX_RECORDS];
    logic                w_greater [MAX_RECORDS];

    assign o_in_stall  = r_drain;
    assign w_in_acc    = i_in_valid && !r_drain;
    assign o_out_valid = r_drain;
    assign w_out_acc   = r_drain && !i_out_stall;
    assign w_full      = w_valid[MAX_RECORDS-1];

    assign w_ctl.insert  = w_in_acc && !w_full;
    assign w_ctl.advance = w_out_acc;

    genvar g;
    generate
        for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
            logic                w_pg;
            logic                w_pv;
            logic [KEY_BITS-1:0] w_pk;
            logic [TAG_BITS-1:0] w_pt;
            logic                w_nv;
            logic [KEY_BITS-1:0] w_nk;
            logic [TAG_BITS-1:0] w_nt;

            if (g == 0) begin : g_head
                assign w_pg = 1'b0;
                assign w_pv = 1'b0;
                assign w_pk = '0;
                assign w_pt = '0;
            end else begin : g_body
                assign w_pg = w_greater[g-1];
                assign w_pv = w_valid[g-1];
                assign w_pk = w_key[g-1];
                assign w_pt = w_tag[g-1];
            end

            if (g == MAX_RECORDS - 1) begin : g_tail
                assign w_nv = 1'b0;
                assign w_nk = '0;
                assign w_nt = '0;
            end else begin : g_mid
                assign w_nv = w_valid[g+1];
                assign w_nk = w_key[g+1];
                assign w_nt = w_tag[g+1];
            end

            srs_cell #(
                .KEY_BITS(KEY_BITS),
                .TAG_BITS(TAG_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (w_ctl),
                .i_new_key      (i_key),
                .i_new_tag      (i_tag),
                .i_prev_greater (w_pg),
                .i_prev_valid   (w_pv),
                .i_prev_key     (w_pk),
                .i_prev_tag     (w_pt),
                .i_next_valid   (w_nv),
                .i_next_key     (w_nk),
                .i_next_tag     (w_nt),
                .o_greater      (w_greater[g]),
                .o_valid        (w_valid[g]),
                .o_key          (w_key[g]),
                .o_tag          (w_tag[g])
            );
        end
    endgenerate

    assign o_sorted_key   = w_key[0];
    assign o_sorted_tag   = w_tag[0];
    assign o_end_of_batch = !w_valid[1];
    assign o_overflow     = r_ovf;

    always_comb begin
        n_drain = r_drain;
        n_ovf   = r_ovf;
        priority if (w_in_acc) begin
            // drop the record when the chain is full
            n_ovf   = r_ovf || w_full;
            n_drain = i_last_record;
        end else if (w_out_acc && o_end_of_batch) begin
            n_drain = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_drain <= n_drain;
            r_ovf   <= n_ovf;
        end
    end

`ifndef ASSERT_OFF
    a_head_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_valid[0])
        else $error("draining with an empty chain head");

    a_sorted_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain && w_valid[1]) |-> (w_key[0] <= w_key[1]))
        else $error("chain head out of order");

    a_empty_after : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_end_of_batch) |=> (!w_valid[0] && !r_drain && !r_ovf))
        else $error("chain not empty after batch end");
`endif

endmodule

// ----- rtl/srs_cell.sv -----
module srs_cell
    import srs_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_new_key,
    input  logic [TAG_BITS-1:0] i_new_tag,
    input  logic                i_prev_greater,
    input  logic                i_prev_valid,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic [TAG_BITS-1:0] i_prev_tag,
    input  logic                i_next_valid,
    input  logic [KEY_BITS-1:0] i_next_key,
    input  logic [TAG_BITS-1:0] i_next_tag,
    output logic                o_greater,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [TAG_BITS-1:0] o_tag
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                n_valid;
    logic [KEY_BITS-1:0] n_key;
    logic [TAG_BITS-1:0] n_tag;

    // An empty cell counts as greater so the new record lands in the first hole.
    // Strict compare keeps equal keys in arrival order.
    assign o_greater = !r_valid || (r_key > i_new_key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        priority if (i_ctl.insert) begin
            if (i_prev_greater) begin
                n_valid = i_prev_valid;
                n_key   = i_prev_key;
                n_tag   = i_prev_tag;
            end else if (o_greater) begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_tag   = i_new_tag;
            end
        end else if (i_ctl.advance) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
            n_tag   = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_tag   = r_tag;

endmodule

// ----- dv/stable_record_sorter_checker.sv -----
module stable_record_sorter_checker
    import srs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [KEY_BITS_DEF-1:0] i_key,
    input  logic [TAG_BITS_DEF-1:0] i_tag,
    input  logic                    i_last_record,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [KEY_BITS_DEF-1:0] i_sorted_key,
    input  logic [TAG_BITS_DEF-1:0] i_sorted_tag,
    input  logic                    i_end_of_batch,
    input  logic                    i_overflow,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [KEY_BITS_DEF-1:0] key;
        logic [TAG_BITS_DEF-1:0] tag;
        logic                    end_of_batch;
        logic                    overflow;
    } t_sorted_rec;

    // Ordered copy of the batch collected so far
    logic [KEY_BITS_DEF-1:0] batch_keys [MAX_RECORDS_DEF];
    logic [TAG_BITS_DEF-1:0] batch_tags [MAX_RECORDS_DEF];
    int                      batch_fill    = 0;
    logic                    batch_dropped = 1'b0;

    t_sorted_rec sorted_due [$];
    t_sorted_rec want;
    int          slot;
    int          errs;
    int          fail_total = 0;
    int          due_total  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;

    function automatic int field_mismatch(input string name, input logic [63:0] exp_val,
                                          input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        errs = 0;
        if (!i_rst_n) begin
            batch_fill    = 0;
            batch_dropped = 1'b0;
            sorted_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sorted_due.size() == 0) begin
                    $error("sorted record with nothing outstanding: key %0h, tag %0h",
                           i_sorted_key, i_sorted_tag);
                    errs++;
                end else begin
                    want = sorted_due.pop_front();
                    errs += field_mismatch("sorted_key", 64'(want.key), 64'(i_sorted_key));
                    errs += field_mismatch("sorted_tag", 64'(want.tag), 64'(i_sorted_tag));
                    errs += field_mismatch("end_of_batch", 64'(want.end_of_batch),
                                           64'(i_end_of_batch));
                    errs += field_mismatch("overflow", 64'(want.overflow), 64'(i_overflow));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (batch_fill < MAX_RECORDS_DEF) begin
                    // shift strictly larger keys up so equal keys keep arrival order
                    slot = batch_fill;
                    while (slot > 0 && batch_keys[slot-1] > i_key) begin
                        batch_keys[slot] = batch_keys[slot-1];
                        batch_tags[slot] = batch_tags[slot-1];
                        slot--;
                    end
                    batch_keys[slot] = i_key;
                    batch_tags[slot] = i_tag;
                    batch_fill++;
                end else begin
                    batch_dropped = 1'b1;
                end
                if (i_last_record) begin
                    for (int i = 0; i < batch_fill; i++) begin
                        want.key          = batch_keys[i];
                        want.tag          = batch_tags[i];
                        want.end_of_batch = (i == batch_fill - 1);
                        want.overflow     = batch_dropped;
                        sorted_due        = {sorted_due, want};
                    end
                    batch_fill    = 0;
                    batch_dropped = 1'b0;
                end
            end
        end
        due_total  <= sorted_due.size();
        fail_total <= fail_total + errs;
    end

endmodule

// ----- dv/stable_record_sorter_test.sv -----
module stable_record_sorter_test
    import srs_pkg::*;
();

    typedef enum int {
        KEYS_WIDE,
        KEYS_CROWDED,
        KEYS_EXTREMES,
        KEYS_CLUSTERED
    } t_key_mix;

    localparam int RECORD_TARGET = 410;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic [KEY_BITS_DEF-1:0] i_key         = '0;
    logic [TAG_BITS_DEF-1:0] i_tag         = '0;
    logic                    i_last_record = 1'b0;
    logic                    i_out_stall   = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [KEY_BITS_DEF-1:0] o_sorted_key;
    logic [TAG_BITS_DEF-1:0] o_sorted_tag;
    logic                    o_end_of_batch;
    logic                    o_overflow;

    int fail_count;
    int due_count;

    int       records_sent = 0;
    int       tx_left      = 0;
    bit       tx_calm      = 1'b0;
    int       rx_left      = 0;
    bit       rx_calm      = 1'b0;
    int       rx_wait;
    int       batch_no;
    int       batch_len;
    t_key_mix key_mix;
    logic [KEY_BITS_DEF-1:0] rand_key;

    stable_record_sorter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .i_last_record  (i_last_record),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_key   (o_sorted_key),
        .o_sorted_tag   (o_sorted_tag),
        .o_end_of_batch (o_end_of_batch),
        .o_overflow     (o_overflow)
    );

    stable_record_sorter_checker sort_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .i_last_record  (i_last_record),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_sorted_key   (o_sorted_key),
        .i_sorted_tag   (o_sorted_tag),
        .i_end_of_batch (o_end_of_batch),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (due_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Switch at random between runs of back-to-back transactions and runs of random waits
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            calm     = ($urandom_range(3, 0) == 0);
            run_left = $urandom_range(40, 8);
        end
        run_left--;
        return calm ? 0 : $urandom_range(16, 0);
    endfunction

    task automatic send_record(input logic [KEY_BITS_DEF-1:0] k,
                               input logic [TAG_BITS_DEF-1:0] t, input logic lst);
        int gap;
        gap = draw_wait(tx_left, tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_key         <= k;
        i_tag         <= t;
        i_last_record <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        records_sent++;
    endtask

    // Hold the input until every predicted result has drained
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
    endtask

    initial begin
        forever begin
            rx_wait = draw_wait(rx_left, rx_calm);
            if (rx_wait > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_wait) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single record batch at the bottom of both ranges
        send_record('0, '0, 1'b1);
        // extremes, out of order
        send_record('1, '1, 1'b0);
        send_record('0, 16'h0001, 1'b0);
        send_record('1, 16'h0002, 1'b0);
        send_record({1'b1, {(KEY_BITS_DEF-1){1'b0}}}, 16'h0003, 1'b0);
        send_record(KEY_BITS_DEF'(1), 16'h0004, 1'b1);
        // runs of equal keys must keep arrival order
        send_record(KEY_BITS_DEF'(5), 16'h0010, 1'b0);
        send_record(KEY_BITS_DEF'(3), 16'h0011, 1'b0);
        send_record(KEY_BITS_DEF'(5), 16'h0012, 1'b0);
        send_record(KEY_BITS_DEF'(5), 16'h0013, 1'b0);
        send_record(KEY_BITS_DEF'(3), 16'h0014, 1'b0);
        send_record(KEY_BITS_DEF'(0), 16'h0015, 1'b0);
        send_record(KEY_BITS_DEF'(5), 16'h0016, 1'b1);
        // descending pair with alternating bit patterns
        send_record({(KEY_BITS_DEF/2){2'b10}}, 16'h5555, 1'b0);
        send_record({(KEY_BITS_DEF/2){2'b01}}, 16'haaaa, 1'b1);
        wait_drained();

        // first a batch that fills the store exactly, then one that drops the last records
        batch_no = 0;
        while (records_sent < RECORD_TARGET) begin
            if (batch_no == 0)
                batch_len = MAX_RECORDS_DEF;
            else if (batch_no == 1)
                batch_len = MAX_RECORDS_DEF + 3;
            else if ($urandom_range(15, 0) == 0)
                batch_len = $urandom_range(MAX_RECORDS_DEF + 6, MAX_RECORDS_DEF - 6);
            else
                batch_len = $urandom_range(12, 1);
            key_mix = t_key_mix'($urandom_range(3, 0));
            for (int r = 0; r < batch_len; r++) begin
                case (key_mix)
                    KEYS_WIDE: begin
                        rand_key = {$urandom, $urandom};
                    end
                    KEYS_CROWDED: begin
                        rand_key = KEY_BITS_DEF'($urandom_range(7, 0));
                    end
                    KEYS_EXTREMES: begin
                        case ($urandom_range(2, 0))
                            0:       rand_key = '0;
                            1:       rand_key = '1;
                            default: rand_key = {$urandom, $urandom};
                        endcase
                    end
                    default: begin
                        rand_key = {2'($urandom_range(3, 0)), {(KEY_BITS_DEF-18){1'b0}},
                                    16'($urandom_range(3, 0))};
                    end
                endcase
                send_record(rand_key, TAG_BITS_DEF'($urandom), r == batch_len - 1);
            end
            if ($urandom_range(5, 0) == 0)
                wait_drained();
            batch_no++;
        end

        wait_drained();
        repeat (2 * MAX_RECORDS_DEF) @(posedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/srs_pkg.sv
rtl/srs_cell.sv
rtl/stable_record_sorter.sv
dv/stable_record_sorter_checker.sv
dv/stable_record_sorter_test.sv
